// ===== rtl/atr_pkg.sv =====
// shared types and constants for the tape receiver
package atr_pkg;

  // pacing accumulator width
  localparam int unsigned ACC_W = 24;

  // widths of the configuration registers
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned CPB_W   = 16;
  localparam int unsigned DELAY_W = 19;
  localparam int unsigned CFG_W   = 19;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LENGTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_PERIOD       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_START_DELAY = 2'd2;

  // configuration reset values
  localparam logic [LEN_W-1:0]   RST_TAPE_LENGTH       = 17'd0;
  localparam logic [CPB_W-1:0]   RST_BYTE_PERIOD       = 16'd1667;
  localparam logic [DELAY_W-1:0] RST_MOTOR_START_DELAY = 19'd400000;

  // item operations
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_READ_STATUS = 3'd1,
    OP_READ_DATA   = 3'd2,
    OP_WRITE_CTRL  = 3'd3,
    OP_SET_MOTOR   = 3'd4,
    OP_LOAD_BYTE   = 3'd5
  } op_e;

  // interrupt event codes
  localparam logic [1:0] IRQ_NONE     = 2'd0;
  localparam logic [1:0] IRQ_DEASSERT = 2'd1;
  localparam logic [1:0] IRQ_ASSERT   = 2'd2;

  // status and control bits
  localparam logic [7:0] STAT_BASE    = 8'h02;
  localparam int unsigned STAT_RX_FULL_BIT = 0;
  localparam int unsigned STAT_NO_DCD_BIT  = 2;
  localparam int unsigned STAT_IRQ_BIT     = 7;
  localparam int unsigned CTRL_IRQ_EN_BIT  = 7;
  localparam logic [1:0] CTRL_MASTER_RESET = 2'b11;

  // one input transaction
  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  elapsed_cycles;
    logic [7:0]  value;
    logic [15:0] tape_addr;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] irq_event;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [LEN_W-1:0]   tape_length;
    logic [CPB_W-1:0]   byte_period;
    logic [DELAY_W-1:0] motor_start_delay;
  } cfg_t;

  // tape store access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== rtl/atr_chan_if.sv =====
// valid/ready channel carrying one payload type
interface atr_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/atr_tape_mem.sv =====
// tape byte store, one write and one registered read port
module atr_tape_mem #(
  parameter int unsigned TAPE_DEPTH = 65536,
  parameter int unsigned AW         = $clog2(TAPE_DEPTH)
) (
  input  logic               clk_i,
  input  atr_pkg::mem_ctl_t  ctl_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [7:0]         wr_data_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0] mem_q [TAPE_DEPTH];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/atr_ctrl.sv =====
// receiver state, pacing and register access decode
module atr_ctrl #(
  parameter int unsigned TAPE_DEPTH = 65536,
  parameter int unsigned AW         = $clog2(TAPE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  atr_pkg::in_item_t    item_i,
  input  atr_pkg::cfg_t        cfg_i,
  input  logic [7:0]           rd_data_i,
  output atr_pkg::out_item_t   res_o,
  output atr_pkg::mem_ctl_t    mem_ctl_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [7:0]           wr_data_o
);

  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = (PW > atr_pkg::LEN_W) ? PW : atr_pkg::LEN_W;

  logic                            rx_full_q, rx_full_d;
  logic                            rx_loaded_q, rx_loaded_d;
  logic                            irq_en_q, irq_en_d;
  logic                            motor_q, motor_d;
  logic                            running_q, running_d;
  logic signed [atr_pkg::ACC_W-1:0] pace_q, pace_d;
  logic [PW-1:0]                   pos_q, pos_d;

  logic                            before_end;
  logic                            addr_ok;
  logic signed [atr_pkg::ACC_W-1:0] sum;
  logic signed [atr_pkg::ACC_W-1:0] cpb_s;
  logic [7:0]                      rx_byte;
  logic [7:0]                      status;

  // tape end and load range checks
  assign before_end = (CW'(pos_q) < CW'(cfg_i.tape_length)) && (CW'(pos_q) < CW'(TAPE_DEPTH));
  assign addr_ok    = CW'(item_i.tape_addr) < CW'(TAPE_DEPTH);

  // pacing sum for a tick
  assign sum   = pace_q + $signed(atr_pkg::ACC_W'(item_i.elapsed_cycles));
  assign cpb_s = $signed(atr_pkg::ACC_W'(cfg_i.byte_period));

  // receive byte lives in the store read register once a byte has arrived
  assign rx_byte = rx_loaded_q ? rd_data_i : 8'h00;

  // status byte
  always_comb begin
    status = atr_pkg::STAT_BASE;
    status[atr_pkg::STAT_RX_FULL_BIT] = rx_full_q;
    status[atr_pkg::STAT_NO_DCD_BIT]  = ~motor_q;
    status[atr_pkg::STAT_IRQ_BIT]     = irq_en_q & rx_full_q;
  end

  // store addresses
  assign rd_addr_o = pos_q[AW-1:0];
  assign wr_addr_o = AW'(item_i.tape_addr);
  assign wr_data_o = item_i.value;

  // per-transaction state update
  always_comb begin
    rx_full_d   = rx_full_q;
    rx_loaded_d = rx_loaded_q;
    irq_en_d    = irq_en_q;
    motor_d     = motor_q;
    running_d   = running_q;
    pace_d      = pace_q;
    pos_d       = pos_q;
    res_o       = '{read_value: 8'h00, irq_event: atr_pkg::IRQ_NONE};
    mem_ctl_o   = '{rd_en: 1'b0, wr_en: 1'b0};
    if (fire_i) begin
      unique case (atr_pkg::op_e'(item_i.op))
        atr_pkg::OP_TICK: begin
          if (running_q && before_end && !rx_full_q) begin
            pace_d = sum;
            if (sum >= cpb_s) begin
              pace_d          = sum - cpb_s;
              pos_d           = pos_q + PW'(1);
              rx_full_d       = 1'b1;
              rx_loaded_d     = 1'b1;
              mem_ctl_o.rd_en = 1'b1;
              if (irq_en_q) begin
                res_o.irq_event = atr_pkg::IRQ_ASSERT;
              end
            end
          end
        end
        atr_pkg::OP_READ_STATUS: begin
          res_o.read_value = status;
        end
        atr_pkg::OP_READ_DATA: begin
          res_o.read_value = rx_byte;
          res_o.irq_event  = atr_pkg::IRQ_DEASSERT;
          rx_full_d        = 1'b0;
        end
        atr_pkg::OP_WRITE_CTRL: begin
          irq_en_d = item_i.value[atr_pkg::CTRL_IRQ_EN_BIT];
          if (item_i.value[1:0] == atr_pkg::CTRL_MASTER_RESET) begin
            rx_full_d       = 1'b0;
            res_o.irq_event = atr_pkg::IRQ_DEASSERT;
          end else if (!irq_en_q && item_i.value[atr_pkg::CTRL_IRQ_EN_BIT] && rx_full_q) begin
            res_o.irq_event = atr_pkg::IRQ_ASSERT;
          end
        end
        atr_pkg::OP_SET_MOTOR: begin
          if (item_i.value[0] != motor_q) begin
            motor_d = item_i.value[0];
            if (item_i.value[0]) begin
              pace_d    = -$signed(atr_pkg::ACC_W'(cfg_i.motor_start_delay));
              rx_full_d = 1'b0;
              running_d = 1'b1;
            end
          end
        end
        atr_pkg::OP_LOAD_BYTE: begin
          mem_ctl_o.wr_en = addr_ok;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_full_q   <= 1'b0;
      rx_loaded_q <= 1'b0;
      irq_en_q    <= 1'b0;
      motor_q     <= 1'b0;
      running_q   <= 1'b0;
      pace_q      <= '0;
      pos_q       <= '0;
    end else begin
      rx_full_q   <= rx_full_d;
      rx_loaded_q <= rx_loaded_d;
      irq_en_q    <= irq_en_d;
      motor_q     <= motor_d;
      running_q   <= running_d;
      pace_q      <= pace_d;
      pos_q       <= pos_d;
    end
  end

endmodule

// ===== rtl/acia_tape_receiver.sv =====
// top level of the tape-fed serial receiver
//
//   port      dir  payload             transaction when
//   in_i      in   op, elapsed_cycles, in_i.valid & in_i.ready
//                  value, tape_addr
//   out_o     out  read_value,         out_o.valid & out_o.ready
//                  irq_event
//   cfg_*     in   index, data         cfg_we_i
//
// one transaction per cycle while in_i.ready is high; its result is in the output register the next cycle
// a delivered byte is read from the tape store and kept in the store read register,
// which the next data read already sees
// in_i.ready is high while the output register is empty or being taken
// reset clears control state only; the tape store holds garbage until loaded
module acia_tape_receiver #(
  parameter int unsigned TAPE_DEPTH = 65536
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  atr_chan_if.sink                            in_i,
  atr_chan_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [atr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [atr_pkg::CFG_W-1:0]           cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TAPE_DEPTH);

  atr_pkg::cfg_t      cfg_q;
  atr_pkg::in_item_t  item;
  atr_pkg::out_item_t res;
  atr_pkg::out_item_t out_data_q;
  atr_pkg::mem_ctl_t  mem_ctl;
  logic               out_valid_q;
  logic               in_ready;
  logic               in_fire;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         rd_data;

  assign item     = in_i.data;
  assign in_ready = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tape_length       <= atr_pkg::RST_TAPE_LENGTH;
      cfg_q.byte_period       <= atr_pkg::RST_BYTE_PERIOD;
      cfg_q.motor_start_delay <= atr_pkg::RST_MOTOR_START_DELAY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        atr_pkg::CFG_TAPE_LENGTH: begin
          cfg_q.tape_length <= cfg_wdata_i[atr_pkg::LEN_W-1:0];
        end
        atr_pkg::CFG_BYTE_PERIOD: begin
          cfg_q.byte_period <= cfg_wdata_i[atr_pkg::CPB_W-1:0];
        end
        atr_pkg::CFG_MOTOR_START_DELAY: begin
          cfg_q.motor_start_delay <= cfg_wdata_i[atr_pkg::DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  atr_ctrl #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .item_i    (item),
    .cfg_i     (cfg_q),
    .rd_data_i (rd_data),
    .res_o     (res),
    .mem_ctl_o (mem_ctl),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  atr_tape_mem #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

  // a store read only comes from an accepted tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.rd_en |-> (in_fire && item.op == atr_pkg::OP_TICK))
    else $error("tape store read without an accepted tick");

  // a store write only comes from an accepted load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> (in_fire && item.op == atr_pkg::OP_LOAD_BYTE))
    else $error("tape store write without an accepted load");

  // every accepted transaction leaves a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");

  // an interrupt raised by a delivery is kept in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mem_ctl.rd_en && res.irq_event == atr_pkg::IRQ_ASSERT)
      |=> (out_data_q.irq_event == atr_pkg::IRQ_ASSERT))
    else $error("delivery interrupt event lost");

endmodule
